>>> src/ils_pkg.sv
// ----------------------------------------------------------------------------
// ils_pkg
// shared types and constants for the indexed list store
// ----------------------------------------------------------------------------
package ils_pkg;

  // default capacity and entry width
  localparam int DEPTH_DEF = 16;
  localparam int WIDTH_DEF = 32;

  // fixed field widths of the command and result words
  localparam int CMD_W = 3;
  localparam int POS_W = 4;
  localparam int VAL_W = 32;
  localparam int IDX_W = 4;
  localparam int CNT_W = 5;
  localparam int ST_W  = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH   = 3'd0,
    CMD_POP    = 3'd1,
    CMD_INSERT = 3'd2,
    CMD_DELETE = 3'd3,
    CMD_READ   = 3'd4,
    CMD_FIND   = 3'd5,
    CMD_REMOVE = 3'd6
  } cmd_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 3'd0,
    ST_RANGE    = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] item_value;
  } req_t;

  typedef struct packed {
    logic [VAL_W-1:0] read_value;
    logic [IDX_W-1:0] found_index;
    logic [CNT_W-1:0] removed_count;
    logic [ST_W-1:0]  status;
    logic [CNT_W-1:0] entry_count;
    logic             is_empty;
  } rsp_t;

endpackage

>>> src/ils_ram.sv
// ----------------------------------------------------------------------------
// ils_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module ils_ram #(
  parameter int W = ils_pkg::WIDTH_DEF,
  parameter int D = ils_pkg::DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic                 re,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/indexed_list_store.sv
// ----------------------------------------------------------------------------
// indexed_list_store
// fixed-capacity ordered list of words kept in one ram
// ----------------------------------------------------------------------------
// A command word is taken when start is high and busy is low; exactly one
// result word follows, shown on result for one cycle with done high, and it
// cannot be held off. Push, commands that fail their checks, an insert at
// the count, a remove on an empty list and the unused command code answer
// in the cycle after acceptance. Pop and read answer from S_WAIT with the
// registered read data. Find walks the entries and stops at the first
// match, remove and delete compact the list, and insert at p below count
// shifts the entries from p up and then places the value in S_TAIL. The
// walks are bound by the single read port of the entry ram: the shift,
// find and remove walks stream one entry per cycle through it, writing
// back behind the read pointer. busy stays high for the whole walk; a new
// command may be taken in the same cycle that the previous result is shown.
// Entries above the count are never read, so the ram needs no clearing.
// ----------------------------------------------------------------------------
module indexed_list_store #(
  parameter int DEPTH = ils_pkg::DEPTH_DEF,
  parameter int WIDTH = ils_pkg::WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  ils_pkg::req_t request,
  output logic          done,
  output ils_pkg::rsp_t result
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  // common width for comparing the position against the count
  localparam int PW = (CW > ils_pkg::POS_W) ? CW : ils_pkg::POS_W;
  // common width for moving values between the 32-bit fields and the ram
  localparam int XW = (WIDTH > ils_pkg::VAL_W) ? WIDTH : ils_pkg::VAL_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,  // waiting for a command
    S_WAIT = 4'b0010,  // single read in flight
    S_SCAN = 4'b0100,  // streaming walk over the entries
    S_TAIL = 4'b1000   // insert: place the new value after the shift
  } state_t;

  state_t              state, state_next;
  logic [CW-1:0]       count, count_next;
  ils_pkg::cmd_t       op, op_next;
  logic [WIDTH-1:0]    val_r, val_next;
  logic [AW-1:0]       pos_r, pos_next;
  logic [CW-1:0]       scan_ptr, scan_ptr_next;   // next address to read
  logic [CW-1:0]       scan_left, scan_left_next; // reads still to issue
  logic [CW-1:0]       wr_ptr, wr_ptr_next;       // compaction write pointer
  logic [CW-1:0]       removed, removed_next;
  logic                pend, pend_next;           // read data arrives now
  logic [AW-1:0]       pend_idx, pend_idx_next;   // index of that data
  logic                done_next;
  ils_pkg::rsp_t       res_next;

  // ram ports
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [WIDTH-1:0]    mem_wdata;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic [WIDTH-1:0]    mem_rdata;

  // command decode
  logic                accept;
  ils_pkg::cmd_t       cmd_in;
  logic [PW-1:0]       pos_x, cnt_x;
  logic [XW-1:0]       val_x, rd_x;
  logic [WIDTH-1:0]    val_w;
  logic                full;
  logic [CW-1:0]       cnt_inc, cnt_dec;
  logic                match;
  logic                keep;

  // response pieces, gathered when the command finishes
  logic                fin;
  logic [WIDTH-1:0]    rsp_read;
  logic [AW-1:0]       rsp_idx;
  logic [CW-1:0]       rsp_removed;
  ils_pkg::status_t    rsp_status;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign cmd_in = ils_pkg::cmd_t'(request.command);
  assign pos_x  = PW'(request.position);
  assign cnt_x  = PW'(count);
  assign val_x  = XW'(request.item_value);
  assign val_w  = val_x[WIDTH-1:0];
  assign full   = (count == CW'(DEPTH));
  assign cnt_inc = count + 1'b1;
  assign cnt_dec = count - 1'b1;
  assign match  = (mem_rdata == val_r);
  assign keep   = (op == ils_pkg::CMD_REMOVE) ? !match : (pend_idx != pos_r);
  assign rd_x   = XW'(rsp_read);

  ils_ram #(
    .W (WIDTH),
    .D (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_next     = state;
    count_next     = count;
    op_next        = op;
    val_next       = val_r;
    pos_next       = pos_r;
    scan_ptr_next  = scan_ptr;
    scan_left_next = scan_left;
    wr_ptr_next    = wr_ptr;
    removed_next   = removed;
    pend_next      = 1'b0;
    pend_idx_next  = pend_idx;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = '0;
    rd_en          = 1'b0;
    rd_addr        = '0;
    fin            = 1'b0;
    rsp_read       = '0;
    rsp_idx        = '0;
    rsp_removed    = '0;
    rsp_status     = ils_pkg::ST_OK;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          op_next  = cmd_in;
          val_next = val_w;
          pos_next = pos_x[AW-1:0];
          unique case (cmd_in)
            ils_pkg::CMD_PUSH: begin
              fin = 1'b1;
              if (full) begin
                rsp_status = ils_pkg::ST_FULL;
              end else begin
                mem_we     = 1'b1;
                mem_waddr  = count[AW-1:0];
                mem_wdata  = val_w;
                count_next = cnt_inc;
              end
            end
            ils_pkg::CMD_POP: begin
              if (count == '0) begin
                fin        = 1'b1;
                rsp_status = ils_pkg::ST_EMPTY;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = cnt_dec[AW-1:0];
                count_next = cnt_dec;
                state_next = S_WAIT;
              end
            end
            ils_pkg::CMD_INSERT: begin
              if (pos_x > cnt_x) begin
                fin        = 1'b1;
                rsp_status = ils_pkg::ST_RANGE;
              end else if (full) begin
                fin        = 1'b1;
                rsp_status = ils_pkg::ST_FULL;
              end else if (pos_x == cnt_x) begin
                // append at the end, nothing to shift
                fin        = 1'b1;
                mem_we     = 1'b1;
                mem_waddr  = pos_x[AW-1:0];
                mem_wdata  = val_w;
                count_next = cnt_inc;
              end else begin
                // walk down from the last entry, each one moves up by one
                scan_ptr_next  = cnt_dec;
                scan_left_next = count - CW'(pos_x);
                state_next     = S_SCAN;
              end
            end
            ils_pkg::CMD_DELETE: begin
              if (pos_x >= cnt_x) begin
                fin        = 1'b1;
                rsp_status = ils_pkg::ST_RANGE;
              end else begin
                // compaction from the position, skipping that one entry
                scan_ptr_next  = CW'(pos_x);
                scan_left_next = count - CW'(pos_x);
                wr_ptr_next    = CW'(pos_x);
                removed_next   = '0;
                state_next     = S_SCAN;
              end
            end
            ils_pkg::CMD_READ: begin
              if (pos_x >= cnt_x) begin
                fin        = 1'b1;
                rsp_status = ils_pkg::ST_RANGE;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = pos_x[AW-1:0];
                state_next = S_WAIT;
              end
            end
            ils_pkg::CMD_FIND: begin
              if (count == '0) begin
                fin        = 1'b1;
                rsp_status = ils_pkg::ST_NOTFOUND;
              end else begin
                scan_ptr_next  = '0;
                scan_left_next = count;
                state_next     = S_SCAN;
              end
            end
            ils_pkg::CMD_REMOVE: begin
              if (count == '0) begin
                fin = 1'b1;
              end else begin
                // compaction over the whole list, dropping matches
                scan_ptr_next  = '0;
                scan_left_next = count;
                wr_ptr_next    = '0;
                removed_next   = '0;
                state_next     = S_SCAN;
              end
            end
            default: begin
              // unused command code: no operation
              fin = 1'b1;
            end
          endcase
        end
      end

      S_WAIT: begin
        fin        = 1'b1;
        rsp_read   = mem_rdata;
        state_next = S_IDLE;
      end

      S_SCAN: begin
        // read side: one entry per cycle
        if (scan_left != '0) begin
          rd_en          = 1'b1;
          rd_addr        = scan_ptr[AW-1:0];
          scan_ptr_next  = (op == ils_pkg::CMD_INSERT) ? scan_ptr - 1'b1
                                                       : scan_ptr + 1'b1;
          scan_left_next = scan_left - 1'b1;
          pend_next      = 1'b1;
          pend_idx_next  = scan_ptr[AW-1:0];
        end
        // data side: act on the entry read last cycle
        if (pend) begin
          priority case (op)
            ils_pkg::CMD_FIND: begin
              if (match) begin
                fin        = 1'b1;
                rsp_idx    = pend_idx;
                pend_next  = 1'b0;
                state_next = S_IDLE;
              end
            end
            ils_pkg::CMD_INSERT: begin
              mem_we    = 1'b1;
              mem_waddr = pend_idx + 1'b1;
              mem_wdata = mem_rdata;
            end
            default: begin
              if (keep) begin
                mem_we      = 1'b1;
                mem_waddr   = wr_ptr[AW-1:0];
                mem_wdata   = mem_rdata;
                wr_ptr_next = wr_ptr + 1'b1;
              end else begin
                removed_next = removed + 1'b1;
              end
            end
          endcase
        end else if (scan_left == '0) begin
          priority case (op)
            ils_pkg::CMD_FIND: begin
              fin        = 1'b1;
              rsp_status = ils_pkg::ST_NOTFOUND;
              state_next = S_IDLE;
            end
            ils_pkg::CMD_INSERT: begin
              state_next = S_TAIL;
            end
            default: begin
              fin         = 1'b1;
              count_next  = wr_ptr;
              rsp_removed = (op == ils_pkg::CMD_REMOVE) ? removed : '0;
              state_next  = S_IDLE;
            end
          endcase
        end
      end

      S_TAIL: begin
        fin        = 1'b1;
        mem_we     = 1'b1;
        mem_waddr  = pos_r;
        mem_wdata  = val_r;
        count_next = cnt_inc;
        state_next = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    done_next                = fin;
    res_next.read_value      = rd_x[ils_pkg::VAL_W-1:0];
    res_next.found_index     = ils_pkg::IDX_W'(rsp_idx);
    res_next.removed_count   = ils_pkg::CNT_W'(rsp_removed);
    res_next.status          = rsp_status;
    res_next.entry_count     = ils_pkg::CNT_W'(count_next);
    res_next.is_empty        = (count_next == '0);
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      pend  <= pend_next;
      done  <= done_next;
    end
  end

  // working registers and the result word
  always_ff @(posedge clk) begin
    op        <= op_next;
    val_r     <= val_next;
    pos_r     <= pos_next;
    scan_ptr  <= scan_ptr_next;
    scan_left <= scan_left_next;
    wr_ptr    <= wr_ptr_next;
    removed   <= removed_next;
    pend_idx  <= pend_idx_next;
    if (done_next) begin
      result <= res_next;
    end
  end

  // the count never passes the capacity
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above capacity");

  // a read in flight only exists during a walk
  a_pend_scan: assert property (@(posedge clk) disable iff (rst)
    pend |-> (state == S_SCAN))
    else $error("read data pending outside a walk");

  // during a walk the write-back never hits the entry being read
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && mem_we && rd_en) |-> (mem_waddr != rd_addr))
    else $error("walk write collides with walk read");

  // an accepted command either answers at once or keeps the block busy
  a_accept_next: assert property (@(posedge clk) disable iff (rst)
    accept |=> (done || busy))
    else $error("accepted command neither answered nor in progress");

  // the reported entry count matches the stored count
  a_count_report: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.entry_count == ils_pkg::CNT_W'(count)))
    else $error("reported entry count differs from stored count");

endmodule
